// File: rtl/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the security policy table.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [2:0] OpAdd      = 3'd0;
  localparam logic [2:0] OpClassify = 3'd1;
  localparam logic [2:0] OpFind     = 3'd2;
  localparam logic [2:0] OpDelete   = 3'd3;
  localparam logic [2:0] OpClear    = 3'd4;

  localparam logic [2:0] CfgIface0 = 3'd0;
  localparam logic [2:0] CfgIface1 = 3'd1;
  localparam logic [2:0] CfgIface2 = 3'd2;
  localparam logic [2:0] CfgIface3 = 3'd3;
  localparam logic [2:0] CfgIfCnt  = 3'd4;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_SHIFT_RD, S_SHIFT_WR, S_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] src_nm;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [31:0] loc_ep;
    logic [31:0] rem_ep;
    logic [7:0]  rotate;
    logic [31:0] spi;
  } entry_t;

  typedef struct packed {
    logic        classify;
    logic [31:0] src_addr;
    logic [31:0] src_nm;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [31:0] loc_ep;
    logic [31:0] rem_ep;
  } key_t;

endpackage

// File: rtl/security_policy_table_core.sv
// ----------------------------------------------------------------------------
// security_policy_table_core
// Ordered policy table with add, classify, find, delete and clear.
// ----------------------------------------------------------------------------
// Add, clear and unknown opcodes go straight to the result beat; classify, find
// and delete scan the entries in order, through a read state and a compare
// state per entry, and a delete hit then shifts each later entry down through
// a read state and a write state. A new request is taken the cycle after the
// result beat; output stalls hold the result beat.
// Reset clears the count, interface registers and control; entries stay undefined.
module security_policy_table_core #(
  parameter int unsigned MAX_ENTRIES = spt_pkg::MaxEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] src_netmask_i,
  input  logic [31:0] dst_addr_i,
  input  logic [31:0] dst_netmask_i,
  input  logic [31:0] local_endpoint_i,
  input  logic [31:0] remote_endpoint_i,
  input  logic [7:0]  rotate_amount_i,
  input  logic [31:0] sec_param_index_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status_o,
  output logic [3:0]  entry_index_o,
  output logic [31:0] hit_local_endpoint_o,
  output logic [31:0] hit_remote_endpoint_o,
  output logic [7:0]  hit_rotate_o,
  output logic [31:0] hit_spi_o,
  output logic [4:0]  entry_count_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [spt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import spt_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  entry_t         mem_q [MAX_ENTRIES];
  entry_t         rd_q;
  logic [31:0]    iface_q [4];
  logic [2:0]     ifcnt_q;
  state_e         state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [2:0]     op_q;
  key_t           key_q;
  logic [1:0]     st_q, st_d;
  logic [3:0]     idx_q, idx_d;
  entry_t         hitent_q;
  logic           hitld;
  logic           hit;
  logic           mem_we;
  logic [IdxW-1:0] mem_wa;
  entry_t         mem_wd;
  logic [IdxW-1:0] mem_ra;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != S_IDLE);
  assign out_valid = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) iface_q[k] <= '0;
      ifcnt_q <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        CfgIface0: iface_q[0] <= cfg_data_i;
        CfgIface1: iface_q[1] <= cfg_data_i;
        CfgIface2: iface_q[2] <= cfg_data_i;
        CfgIface3: iface_q[3] <= cfg_data_i;
        CfgIfCnt:  ifcnt_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  spt_match u_match (
    .key_i(key_q), .ent_i(rd_q), .iface_i(iface_q), .iface_cnt_i(ifcnt_q), .hit_o(hit)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall && in_valid) begin
      op_q <= opcode_i;
      key_q.classify <= (opcode_i == OpClassify);
      key_q.src_addr <= src_addr_i;
      key_q.src_nm   <= src_netmask_i;
      key_q.dst_addr <= dst_addr_i;
      key_q.dst_mask <= dst_netmask_i;
      key_q.loc_ep   <= local_endpoint_i;
      key_q.rem_ep   <= remote_endpoint_i;
    end
    if (hitld) hitent_q <= rd_q;
    st_q  <= st_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    st_d    = st_q;
    idx_d   = idx_q;
    hitld   = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = ptr_q[IdxW-1:0];
    mem_wd  = rd_q;
    mem_ra  = ptr_q[IdxW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid) begin
          ptr_d = '0;
          st_d  = StMiss;
          idx_d = '0;
          case (opcode_i)
            OpAdd: begin
              if (cnt_q >= MaxCnt) begin
                st_d = StFull;
              end else begin
                st_d = StOk;
                idx_d = 4'(cnt_q);
              end
              state_d = S_OUT;
            end
            OpClassify, OpFind, OpDelete: begin
              state_d = (cnt_q == '0) ? S_OUT : S_READ;
            end
            OpClear: begin
              st_d = StOk;
              state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        if (hit) begin
          hitld = 1'b1;
          st_d  = StOk;
          idx_d = 4'(ptr_q);
          state_d = (op_q == OpDelete) ? S_SHIFT_RD : S_OUT;
        end else if (ptr_q + CntOne >= cnt_q) begin
          state_d = S_OUT;
        end else begin
          ptr_d = ptr_q + CntOne;
          state_d = S_READ;
        end
      end
      S_SHIFT_RD: begin
        if (ptr_q + CntOne >= cnt_q) begin
          cnt_d = cnt_q - CntOne;
          state_d = S_OUT;
        end else begin
          mem_ra = IdxW'(ptr_q + CntOne);
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
        ptr_d = ptr_q + CntOne;
        state_d = S_SHIFT_RD;
      end
      S_OUT: begin
        if (!out_stall) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_IDLE && in_valid && opcode_i == OpAdd && cnt_q < MaxCnt) begin
      mem_we = 1'b1;
      mem_wa = cnt_q[IdxW-1:0];
      mem_wd.src_addr = src_addr_i & src_netmask_i;
      mem_wd.src_nm   = src_netmask_i;
      mem_wd.dst_addr = dst_addr_i & dst_netmask_i;
      mem_wd.dst_mask = dst_netmask_i;
      mem_wd.loc_ep   = local_endpoint_i;
      mem_wd.rem_ep   = remote_endpoint_i;
      mem_wd.rotate   = rotate_amount_i;
      mem_wd.spi      = sec_param_index_i;
      cnt_d = cnt_q + CntOne;
    end
    if (state_q == S_IDLE && in_valid && opcode_i == OpClear) cnt_d = '0;
  end

  logic show;
  assign show = (st_q == StOk) && (op_q inside {OpClassify, OpFind, OpDelete});

  assign status_o              = st_q;
  assign entry_index_o         = idx_q;
  assign hit_local_endpoint_o  = show ? hitent_q.loc_ep : '0;
  assign hit_remote_endpoint_o = show ? hitent_q.rem_ep : '0;
  assign hit_rotate_o          = show ? hitent_q.rotate : '0;
  assign hit_spi_o             = show ? hitent_q.spi : '0;
  assign entry_count_o         = 5'(cnt_q);

endmodule

// File: rtl/spt_match.sv
// ----------------------------------------------------------------------------
// spt_match
// Shared compare unit: tests one stored entry against the request key.
// ----------------------------------------------------------------------------
module spt_match (
  input  spt_pkg::key_t   key_i,
  input  spt_pkg::entry_t ent_i,
  input  logic [31:0]     iface_i [4],
  input  logic [2:0]      iface_cnt_i,
  output logic            hit_o
);
  import spt_pkg::*;

  logic addr_ok;
  logic exact_ok;
  logic local_ok;

  always_comb begin
    addr_ok = (ent_i.src_addr == (key_i.src_addr & ent_i.src_nm)) &&
              (ent_i.dst_addr == (key_i.dst_addr & ent_i.dst_mask));
    exact_ok = (ent_i.src_nm == key_i.src_nm) &&
               (ent_i.dst_mask == key_i.dst_mask) &&
               (ent_i.loc_ep == key_i.loc_ep) &&
               (ent_i.rem_ep == key_i.rem_ep);
    local_ok = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if ((k < int'(iface_cnt_i) || iface_cnt_i > 3'd4) &&
          iface_i[k] == ent_i.loc_ep) begin
        local_ok = 1'b1;
      end
    end
    hit_o = addr_ok && (key_i.classify ? local_ok : exact_ok);
  end

endmodule

// File: rtl/spt_checker.sv
// ----------------------------------------------------------------------------
// spt_checker
// Port-level checks for the security policy table.
// ----------------------------------------------------------------------------
module spt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status_o,
  input logic [3:0] entry_index_o,
  input logic [4:0] entry_count_o
);
  import spt_pkg::*;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("accepting while result pending");

  a_beat_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall) |=> in_stall) else $error("no work after beat");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (status_o <= StFull)) else $error("bad status");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && status_o == StFull) |-> (entry_index_o == 4'd0))
    else $error("full result with index");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(status_o) &&
                                  $stable(entry_index_o) && $stable(entry_count_o)))
    else $error("stalled result beat changed");

endmodule

bind security_policy_table_core spt_checker u_spt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status_o(status_o),
  .entry_index_o(entry_index_o), .entry_count_o(entry_count_o)
);
